[src/wfss_pkg.sv]
package wfss_pkg;

   // default widths of waves and coefficients
   localparam int DEF_SAMPLE_WIDTH = 24;
   localparam int DEF_COEFF_WIDTH  = 16;

   // one coefficient row as held in a configuration register
   localparam int ROW_W = 64;

   // configuration register index
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ROW0 = 3'd0,
      REG_ROW1 = 3'd1,
      REG_ROW2 = 3'd2,
      REG_BIAS = 3'd3
   } csr_index_type;

endpackage

[src/wave_filter_summing_stage_core.sv]
// channel   ports                        direction  handshake
// req       req_sample_in                in         req_valid / req_stall
// rsp       rsp_sample_out               out        rsp_valid / rsp_stall
// csr       csr_index, csr_wdata         in         csr_wr_en (write only)
//
// rsp_valid rises once the sample has passed the input register and then,
// through the junction, the result register; a stalled result keeps it
// waiting in the input register before the rsp transfer can take place.
// one sample per cycle sustained while rsp_stall is low; the capacitor wave
// loop closes through three multipliers, an adder and a saturator.
// reset is synchronous: coefficients clear, bias returns to 4.5 V, the
// capacitor wave clears and both stages empty.
// a stalled result holds the input stage, which then raises req_stall.
module wave_filter_summing_stage_core
   import wfss_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int COEFF_WIDTH  = DEF_COEFF_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input  logic                           csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [ROW_W-1:0]               csr_wdata
);

   localparam int Y_W = SAMPLE_WIDTH + 2;
   localparam logic signed [SAMPLE_WIDTH-1:0] BIAS_RESET =
      SAMPLE_WIDTH'(9) << (SAMPLE_WIDTH - 6);
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX =
      {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN =
      {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

   logic [ROW_W-1:0]               row_ff [3];
   logic [ROW_W-1:0]               row_in [3];
   logic signed [SAMPLE_WIDTH-1:0] bias_ff;
   logic signed [SAMPLE_WIDTH-1:0] bias_in;
   logic signed [SAMPLE_WIDTH-1:0] cap_ff;
   logic signed [SAMPLE_WIDTH-1:0] cap_in;
   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_sample_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_in;
   logic                           req_xfer;
   logic                           advance;
   logic                           s1_move;
   logic signed [SAMPLE_WIDTH-1:0] wave_b [3];
   logic signed [Y_W-1:0]          y_sum;
   logic signed [Y_W-1:0]          y_half;
   logic [2:0]                     y_top;
   logic signed [SAMPLE_WIDTH-1:0] y_sat;

   // configuration writes
   always_comb begin
      row_in  = row_ff;
      bias_in = bias_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_ROW0: row_in[0] = csr_wdata;
            REG_ROW1: row_in[1] = csr_wdata;
            REG_ROW2: row_in[2] = csr_wdata;
            REG_BIAS: bias_in   = csr_wdata[SAMPLE_WIDTH-1:0];
            default:  bias_in   = bias_ff;
         endcase
      end
   end

   // handshake: result register frees when empty or taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   // reflected waves 0 to 2
   for (genvar r = 0; r < 3; r++) begin : g_row
      wfss_reflect #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .COEFF_WIDTH  (COEFF_WIDTH)
      ) u_reflect (
         .row_coeffs (row_ff[r]),
         .wave_a0    (s1_sample_ff),
         .wave_a2    (cap_ff),
         .wave_a3    (bias_ff),
         .wave_b     (wave_b[r])
      );
   end

   // output (a0 + b0 + b1) / 2, floor, saturated
   assign y_sum  = Y_W'(s1_sample_ff) + Y_W'(wave_b[0]) + Y_W'(wave_b[1]);
   assign y_half = y_sum >>> 1;
   assign y_top  = y_half[Y_W-1:SAMPLE_WIDTH-1];

   always_comb begin
      if ((&y_top) || !(|y_top)) begin
         y_sat = y_half[SAMPLE_WIDTH-1:0];
      end else if (y_half[Y_W-1]) begin
         y_sat = SAT_MIN;
      end else begin
         y_sat = SAT_MAX;
      end
   end

   // stage next values
   always_comb begin
      s1_sample_in  = req_xfer ? req_sample_in : s1_sample_ff;
      s1_valid_in   = req_xfer || (s1_valid_ff && !advance);
      cap_in        = s1_move ? wave_b[2] : cap_ff;
      rsp_sample_in = s1_move ? y_sat : rsp_sample_ff;
      rsp_valid_in  = s1_move || (rsp_valid_ff && rsp_stall);
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]    <= '0;
         row_ff[1]    <= '0;
         row_ff[2]    <= '0;
         bias_ff      <= BIAS_RESET;
         cap_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         bias_ff      <= bias_in;
         cap_ff       <= cap_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_sample_ff  <= s1_sample_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // a sample that leaves the input stage shows up as a result
   a_move_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("sample left input stage without a result");

   // capacitor wave changes only as a sample passes through
   a_cap_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && !s1_move) |=> $stable(cap_ff))
      else $error("capacitor wave changed without a sample");

   // a blocked result keeps the waiting sample in place
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=>
         (s1_valid_ff && $stable(s1_sample_ff)))
      else $error("input stage lost a sample under stall");

endmodule

[src/wfss_reflect.sv]
module wfss_reflect
   import wfss_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int COEFF_WIDTH  = DEF_COEFF_WIDTH
) (
   input  logic [ROW_W-1:0]               row_coeffs,
   input  logic signed [SAMPLE_WIDTH-1:0] wave_a0,
   input  logic signed [SAMPLE_WIDTH-1:0] wave_a2,
   input  logic signed [SAMPLE_WIDTH-1:0] wave_a3,
   output logic signed [SAMPLE_WIDTH-1:0] wave_b
);

   localparam int CF     = COEFF_WIDTH - 3;
   localparam int PROD_W = SAMPLE_WIDTH + COEFF_WIDTH;
   localparam int ACC_W  = PROD_W + 2;
   localparam int PAD_W  = ROW_W + 4 * COEFF_WIDTH;
   localparam logic signed [ACC_W-1:0] RND =
      {{(ACC_W - CF){1'b0}}, 1'b1, {(CF - 1){1'b0}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX =
      {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN =
      {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

   logic [PAD_W-1:0]                padded;
   logic signed [COEFF_WIDTH-1:0]   coef0;
   logic signed [COEFF_WIDTH-1:0]   coef2;
   logic signed [COEFF_WIDTH-1:0]   coef3;
   logic signed [PROD_W-1:0]        prod0;
   logic signed [PROD_W-1:0]        prod2;
   logic signed [PROD_W-1:0]        prod3;
   logic signed [ACC_W-1:0]         acc;
   logic signed [ACC_W-1:0]         scaled;
   logic [ACC_W-SAMPLE_WIDTH:0]     top_bits;

   // coefficient fields, bits past the register read as zero
   assign padded = {{(4 * COEFF_WIDTH){1'b0}}, row_coeffs};
   assign coef0  = signed'(padded[0 +: COEFF_WIDTH]);
   assign coef2  = signed'(padded[2 * COEFF_WIDTH +: COEFF_WIDTH]);
   assign coef3  = signed'(padded[3 * COEFF_WIDTH +: COEFF_WIDTH]);

   // resistor port wave is zero, so column 1 drops out
   assign prod0 = PROD_W'(coef0) * PROD_W'(wave_a0);
   assign prod2 = PROD_W'(coef2) * PROD_W'(wave_a2);
   assign prod3 = PROD_W'(coef3) * PROD_W'(wave_a3);

   // exact sum, round half up, back to wave format
   assign acc      = ACC_W'(prod0) + ACC_W'(prod2) + ACC_W'(prod3) + RND;
   assign scaled   = acc >>> CF;
   assign top_bits = scaled[ACC_W-1:SAMPLE_WIDTH-1];

   // saturate to the wave width
   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         wave_b = scaled[SAMPLE_WIDTH-1:0];
      end else if (scaled[ACC_W-1]) begin
         wave_b = SAT_MIN;
      end else begin
         wave_b = SAT_MAX;
      end
   end

endmodule
